// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL. They are empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// The condition holds whenever the trigger holds, in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// The condition holds in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/wbsd_pkg.sv -----
// ----------------------------------------------------------------------------
// WavPack block sync deframer package
// Types, constants and result codes shared by the deframer modules.
// ----------------------------------------------------------------------------
package wbsd_pkg;

   localparam int WIN_LEN = 32;

   localparam logic [31:0] SIZE_BAD_MASK = 32'hfff0_0001;
   localparam logic [31:0] SIZE_ADJUST   = 32'd8;
   localparam logic [19:0] HDR_LEN       = 20'd32;
   localparam logic [23:0] SKIP_MAX      = 24'hff_ffff;
   localparam logic [23:0] NOSYNC_RESET  = 24'd1048576;

   localparam logic [7:0] MAGIC_0 = 8'h77;  // 'w'
   localparam logic [7:0] MAGIC_1 = 8'h76;  // 'v'
   localparam logic [7:0] MAGIC_2 = 8'h70;  // 'p'
   localparam logic [7:0] MAGIC_3 = 8'h6b;  // 'k'

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_BODY   = 2'd1;
   localparam logic [1:0] KIND_NOSYNC = 2'd2;

   typedef enum logic [1:0] {
      MODE_SEARCH,
      MODE_BODY,
      MODE_STUCK
   } mode_type;

   typedef logic [7:0] byte_type;
   typedef byte_type [WIN_LEN-1:0] win_type;

   typedef struct packed {
      logic        ok;
      logic        has_body;
      logic [19:0] body_len;
      logic [19:0] block_size;
      logic [15:0] version;
      logic [31:0] stream_samples;
      logic [31:0] block_index;
      logic [31:0] sample_count;
   } hdr_type;

endpackage

// ----- rtl/wbsd_hdr_check.sv -----
// ----------------------------------------------------------------------------
// Header check
// Tests a full 32-byte window as a block header and extracts its fields.
// ----------------------------------------------------------------------------
module wbsd_hdr_check (
   input  wbsd_pkg::win_type win,
   output wbsd_pkg::hdr_type hdr
);

   logic [31:0] size_word;
   logic        magic_ok;
   logic        size_ok;
   logic        flag_ok;

   // The size field is little-endian at offset 4 and excludes the first 8 bytes.
   assign size_word = {win[7], win[6], win[5], win[4]} + wbsd_pkg::SIZE_ADJUST;

   assign magic_ok = (win[0] == wbsd_pkg::MAGIC_0) && (win[1] == wbsd_pkg::MAGIC_1) &&
                     (win[2] == wbsd_pkg::MAGIC_2) && (win[3] == wbsd_pkg::MAGIC_3);
   assign size_ok  = (size_word & wbsd_pkg::SIZE_BAD_MASK) == 32'd0;
   assign flag_ok  = !win[27][7];

   always_comb begin
      hdr.ok             = magic_ok && size_ok && flag_ok;
      hdr.block_size     = size_word[19:0];
      hdr.has_body       = size_word[19:0] > wbsd_pkg::HDR_LEN;
      hdr.body_len       = size_word[19:0] - wbsd_pkg::HDR_LEN;
      hdr.version        = {win[9], win[8]};
      hdr.stream_samples = {win[15], win[14], win[13], win[12]};
      hdr.block_index    = {win[19], win[18], win[17], win[16]};
      hdr.sample_count   = {win[23], win[22], win[21], win[20]};
   end

endmodule

// ----- rtl/wavpack_block_sync_deframer.sv -----
// ----------------------------------------------------------------------------
// WavPack block sync deframer
// Finds block headers in a byte stream and passes block bodies through.
// ----------------------------------------------------------------------------
// Bytes enter on the req_ channel, one per request. The last 32 bytes are held
// in a shift window; once it is full it is checked as a header. A good header
// gives one rsp_ result of kind header, then the body bytes follow one result
// per byte with rsp_last on the final one. Each failed check drops one byte;
// when more bytes than the sync limit have been dropped a single no-sync result
// is given and all later bytes are swallowed until reset.
// The sync limit is written through the csr_ channel, which is always ready.
// A request passes through an input register, then through the
// window check and state update into the result register. One byte is taken
// every cycle while the result register is free or being emptied; a stalled
// receiver holds the result and the input register, then req_ready falls.
// Synchronous reset empties the window, clears the counters and both stages,
// and sets the sync limit back to 1048576.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wavpack_block_sync_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_body_byte,
   output logic        rsp_last,
   output logic [19:0] rsp_block_size,
   output logic [15:0] rsp_version,
   output logic [31:0] rsp_stream_samples,
   output logic [31:0] rsp_block_index,
   output logic [31:0] rsp_sample_count,
   output logic [23:0] rsp_skipped_bytes,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_sync_limit
);

   wbsd_pkg::mode_type mode_ff, mode_in;
   wbsd_pkg::win_type  win_ff, win_in, win_next;
   wbsd_pkg::hdr_type  hdr;

   logic [4:0]  fill_ff, fill_in;
   logic [19:0] body_left_ff, body_left_in;
   logic [23:0] skip_ff, skip_in;
   logic [23:0] skip_inc;
   logic [23:0] sync_limit_ff, sync_limit_in;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        advance;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  body_byte_ff, body_byte_in;
   logic        last_ff, last_in;
   logic [19:0] block_size_ff, block_size_in;
   logic [15:0] version_ff, version_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] index_ff, index_in;
   logic [31:0] samples_ff, samples_in;
   logic [23:0] skipped_ff, skipped_in;

   // The processing stage moves only when the result register can take a value.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_comb begin
      for (int i = 0; i < wbsd_pkg::WIN_LEN - 1; i++) begin
         win_next[i] = win_ff[i+1];
      end
      win_next[wbsd_pkg::WIN_LEN-1] = in_byte_ff;
   end

   wbsd_hdr_check u_hdr_check (
      .win (win_next),
      .hdr (hdr)
   );

   assign skip_inc = (skip_ff == wbsd_pkg::SKIP_MAX) ? skip_ff : skip_ff + 24'd1;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      sync_limit_in = sync_limit_ff;
      if (csr_valid && csr_ready) begin
         sync_limit_in = csr_sync_limit;
      end

      mode_in       = mode_ff;
      win_in        = win_ff;
      fill_in       = fill_ff;
      body_left_in  = body_left_ff;
      skip_in       = skip_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      kind_in       = kind_ff;
      body_byte_in  = body_byte_ff;
      last_in       = last_ff;
      block_size_in = block_size_ff;
      version_in    = version_ff;
      total_in      = total_ff;
      index_in      = index_ff;
      samples_in    = samples_ff;
      skipped_in    = skipped_ff;

      if (advance) begin
         case (mode_ff)
            wbsd_pkg::MODE_BODY: begin
               body_left_in  = body_left_ff - 20'd1;
               rsp_valid_in  = 1'b1;
               kind_in       = wbsd_pkg::KIND_BODY;
               body_byte_in  = in_byte_ff;
               last_in       = (body_left_ff == 20'd1);
               block_size_in = '0;
               version_in    = '0;
               total_in      = '0;
               index_in      = '0;
               samples_in    = '0;
               skipped_in    = '0;
               if (body_left_ff == 20'd1) begin
                  mode_in = wbsd_pkg::MODE_SEARCH;
               end
            end
            wbsd_pkg::MODE_SEARCH: begin
               win_in = win_next;
               if (fill_ff != 5'd31) begin
                  fill_in = fill_ff + 5'd1;
               end else if (hdr.ok) begin
                  fill_in       = '0;
                  skip_in       = '0;
                  rsp_valid_in  = 1'b1;
                  kind_in       = wbsd_pkg::KIND_HEADER;
                  body_byte_in  = '0;
                  last_in       = 1'b0;
                  block_size_in = hdr.block_size;
                  version_in    = hdr.version;
                  total_in      = hdr.stream_samples;
                  index_in      = hdr.block_index;
                  samples_in    = hdr.sample_count;
                  skipped_in    = skip_ff;
                  // A block of header length or less carries no body.
                  if (hdr.has_body) begin
                     body_left_in = hdr.body_len;
                     mode_in      = wbsd_pkg::MODE_BODY;
                  end else begin
                     body_left_in = '0;
                  end
               end else begin
                  // The oldest byte drops out; the window stays one short of full.
                  skip_in = skip_inc;
                  if (skip_inc > sync_limit_ff) begin
                     mode_in       = wbsd_pkg::MODE_STUCK;
                     rsp_valid_in  = 1'b1;
                     kind_in       = wbsd_pkg::KIND_NOSYNC;
                     body_byte_in  = '0;
                     last_in       = 1'b0;
                     block_size_in = '0;
                     version_in    = '0;
                     total_in      = '0;
                     index_in      = '0;
                     samples_in    = '0;
                     skipped_in    = skip_inc;
                  end
               end
            end
            default: begin
               // Stuck: the byte is taken and discarded.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= wbsd_pkg::MODE_SEARCH;
         fill_ff       <= '0;
         body_left_ff  <= '0;
         skip_ff       <= '0;
         sync_limit_ff <= wbsd_pkg::NOSYNC_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         mode_ff       <= mode_in;
         fill_ff       <= fill_in;
         body_left_ff  <= body_left_in;
         skip_ff       <= skip_in;
         sync_limit_ff <= sync_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      win_ff        <= win_in;
      kind_ff       <= kind_in;
      body_byte_ff  <= body_byte_in;
      last_ff       <= last_in;
      block_size_ff <= block_size_in;
      version_ff    <= version_in;
      total_ff      <= total_in;
      index_ff      <= index_in;
      samples_ff    <= samples_in;
      skipped_ff    <= skipped_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_body_byte      = body_byte_ff;
   assign rsp_last           = last_ff;
   assign rsp_block_size     = block_size_ff;
   assign rsp_version        = version_ff;
   assign rsp_stream_samples = total_ff;
   assign rsp_block_index    = index_ff;
   assign rsp_sample_count   = samples_ff;
   assign rsp_skipped_bytes  = skipped_ff;

   `ASSERT_NEXT(a_stuck_silent, clock, reset,
      (mode_ff == wbsd_pkg::MODE_STUCK) && !rsp_valid_ff, !rsp_valid_ff)
   `ASSERT_IMPLY(a_body_window_empty, clock, reset,
      mode_ff == wbsd_pkg::MODE_BODY, (fill_ff == 5'd0) && (body_left_ff != 20'd0))
   `ASSERT_IMPLY(a_last_only_on_body, clock, reset,
      rsp_valid_ff && rsp_last, rsp_kind == wbsd_pkg::KIND_BODY)
   `ASSERT_NEXT(a_nosync_enters_stuck, clock, reset,
      advance && (kind_in == wbsd_pkg::KIND_NOSYNC) && rsp_valid_in,
      mode_ff == wbsd_pkg::MODE_STUCK)

endmodule

// ----- tb/wbsd_deframe_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deframer response checker
// Watches the request, response and register channels of the block sync
// deframer. It keeps its own copy of the byte window, body count, skip count
// and limit, works out the response owed for every accepted request, and
// compares each accepted response with the oldest one owed, field by field.
// ----------------------------------------------------------------------------
module wbsd_deframe_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_kind,
   input  logic [7:0]  rsp_body_byte,
   input  logic        rsp_last,
   input  logic [19:0] rsp_block_size,
   input  logic [15:0] rsp_version,
   input  logic [31:0] rsp_stream_samples,
   input  logic [31:0] rsp_block_index,
   input  logic [31:0] rsp_sample_count,
   input  logic [23:0] rsp_skipped_bytes,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [23:0] csr_sync_limit,
   output int          err_count,
   output int          results_due,
   output logic        in_sync
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  body_byte;
      logic        last;
      logic [19:0] block_size;
      logic [15:0] version;
      logic [31:0] stream_samples;
      logic [31:0] block_index;
      logic [31:0] sample_count;
      logic [23:0] skipped_bytes;
   } deframe_out_type;

   deframe_out_type deframed_due [$];
   deframe_out_type due;

   wbsd_pkg::byte_type win [wbsd_pkg::WIN_LEN];
   int unsigned        fill;
   logic [19:0]        body_left;
   logic [23:0]        skip;
   logic [23:0]        limit;
   wbsd_pkg::mode_type mode;

   logic [31:0] want_f [9];
   logic [31:0] seen_f [9];
   string       field_name [9] = '{"kind", "body_byte", "last", "block_size", "version",
                                   "stream_samples", "block_index", "sample_count",
                                   "skipped_bytes"};

   initial begin
      err_count   = 0;
      results_due = 0;
      in_sync     = 1'b0;
   end

   function automatic logic [31:0] window_word(input int unsigned at);
      return {win[at+3], win[at+2], win[at+1], win[at]};
   endfunction

   // Advances the copy of the deframer by one accepted byte.
   task automatic deframe_byte(input wbsd_pkg::byte_type b);
      logic [31:0]     size_word;
      logic [31:0]     flag_word;
      deframe_out_type r;
      r = '0;
      case (mode)
         wbsd_pkg::MODE_BODY: begin
            body_left = body_left - 20'd1;
            r.kind      = wbsd_pkg::KIND_BODY;
            r.body_byte = b;
            r.last      = (body_left == 20'd0);
            deframed_due.push_back(r);
            if (body_left == 20'd0)
               mode = wbsd_pkg::MODE_SEARCH;
         end
         wbsd_pkg::MODE_SEARCH: begin
            win[fill] = b;
            fill++;
            if (fill == wbsd_pkg::WIN_LEN) begin
               size_word = window_word(4) + wbsd_pkg::SIZE_ADJUST;
               flag_word = window_word(24);
               if (win[0] == wbsd_pkg::MAGIC_0 && win[1] == wbsd_pkg::MAGIC_1 &&
                   win[2] == wbsd_pkg::MAGIC_2 && win[3] == wbsd_pkg::MAGIC_3 &&
                   (size_word & wbsd_pkg::SIZE_BAD_MASK) == 32'd0 &&
                   !flag_word[31]) begin
                  r.kind           = wbsd_pkg::KIND_HEADER;
                  r.block_size     = size_word[19:0];
                  r.version        = {win[9], win[8]};
                  r.stream_samples = window_word(12);
                  r.block_index    = window_word(16);
                  r.sample_count   = window_word(20);
                  r.skipped_bytes  = skip;
                  deframed_due.push_back(r);
                  skip = '0;
                  fill = 0;
                  // Blocks of header length or less carry no body at all.
                  if (size_word > {12'd0, wbsd_pkg::HDR_LEN}) begin
                     body_left = size_word[19:0] - wbsd_pkg::HDR_LEN;
                     mode = wbsd_pkg::MODE_BODY;
                  end
               end else begin
                  for (int i = 0; i < wbsd_pkg::WIN_LEN - 1; i++)
                     win[i] = win[i+1];
                  fill = wbsd_pkg::WIN_LEN - 1;
                  if (skip != wbsd_pkg::SKIP_MAX)
                     skip++;
                  if (skip > limit) begin
                     r.kind          = wbsd_pkg::KIND_NOSYNC;
                     r.skipped_bytes = skip;
                     deframed_due.push_back(r);
                     mode = wbsd_pkg::MODE_STUCK;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         deframed_due.delete();
         foreach (win[i])
            win[i] = '0;
         fill      = 0;
         body_left = '0;
         skip      = '0;
         limit     = wbsd_pkg::NOSYNC_RESET;
         mode      = wbsd_pkg::MODE_SEARCH;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (deframed_due.size() == 0) begin
               err_count++;
               $display("%0t: response with nothing owed, kind %0d skipped %0h",
                        $time, rsp_kind, rsp_skipped_bytes);
            end else begin
               due = deframed_due.pop_front();
               want_f = '{32'(due.kind), 32'(due.body_byte), 32'(due.last),
                          32'(due.block_size), 32'(due.version), due.stream_samples,
                          due.block_index, due.sample_count, 32'(due.skipped_bytes)};
               seen_f = '{32'(rsp_kind), 32'(rsp_body_byte), 32'(rsp_last),
                          32'(rsp_block_size), 32'(rsp_version), rsp_stream_samples,
                          rsp_block_index, rsp_sample_count, 32'(rsp_skipped_bytes)};
               for (int i = 0; i < 9; i++) begin
                  if (want_f[i] !== seen_f[i]) begin
                     err_count++;
                     $display("%0t: %s expected %0h, got %0h",
                              $time, field_name[i], want_f[i], seen_f[i]);
                  end
               end
            end
         end
         if (csr_valid && csr_ready)
            limit = csr_sync_limit;
         if (req_valid && req_ready)
            deframe_byte(req_in_byte);
      end
      results_due = deframed_due.size();
      in_sync     = (mode == wbsd_pkg::MODE_SEARCH) && (fill == 0) && (skip == '0);
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block sync deframer testbench
// Feeds the deframer with hand-built block headers, short and wrapped sizes,
// rejected headers, broken and cut-short headers and plain noise, under
// several no-sync limits, and finally drives it into the no-sync error. The
// sender works in bursts and the receiver stalls on its own pattern, with one
// long hold-off that backs the block up. The checker does all comparing.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [31:0] TAG_WVPK = {wbsd_pkg::MAGIC_3, wbsd_pkg::MAGIC_2,
                                       wbsd_pkg::MAGIC_1, wbsd_pkg::MAGIC_0};

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte    = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_body_byte;
   logic        rsp_last;
   logic [19:0] rsp_block_size;
   logic [15:0] rsp_version;
   logic [31:0] rsp_stream_samples;
   logic [31:0] rsp_block_index;
   logic [31:0] rsp_sample_count;
   logic [23:0] rsp_skipped_bytes;
   logic        csr_valid      = 1'b0;
   logic        csr_ready;
   logic [23:0] csr_sync_limit = '0;

   int   err_count;
   int   results_due;
   logic in_sync;
   int   burst_left = 0;
   int   phase_bytes = 0;

   always #6 clock = ~clock;

   wavpack_block_sync_deframer dut (.*);

   wbsd_deframe_check deframe_check (.*);

   initial begin
      #5_000_000;
      $display("FAIL wavpack_block_sync_deframer");
      $finish;
   end

   function automatic logic [31:0] field_value();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   // Mostly small blocks, some with no body, a few larger ones.
   function automatic logic [19:0] pick_block_size();
      case ($urandom_range(0, 19))
         0, 1: return 20'($urandom_range(0, 16) * 2);
         2: return 20'($urandom_range(50, 160) * 2);
         default: return 20'($urandom_range(17, 48) * 2);
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         if (req_valid)
            req_valid <= 1'b0;
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4))
            @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 30);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(negedge clock);
      while (!req_ready)
         @(negedge clock);
      @(posedge clock);
      phase_bytes++;
   endtask

   task automatic send_body(input int n);
      repeat (n) send_byte(8'($urandom()));
   endtask

   // Sends the first keep bytes of a header built from the given words.
   task automatic send_header(input logic [31:0] tag, input logic [31:0] size_word,
                              input logic [15:0] ver, input logic [31:0] total,
                              input logic [31:0] index, input logic [31:0] count,
                              input logic [31:0] flags, input int keep);
      wbsd_pkg::byte_type hdr [32];
      for (int i = 0; i < 4; i++) begin
         hdr[i]    = tag[8*i +: 8];
         hdr[4+i]  = size_word[8*i +: 8];
         hdr[12+i] = total[8*i +: 8];
         hdr[16+i] = index[8*i +: 8];
         hdr[20+i] = count[8*i +: 8];
         hdr[24+i] = flags[8*i +: 8];
         hdr[28+i] = 8'($urandom());
      end
      hdr[8]  = ver[7:0];
      hdr[9]  = ver[15:8];
      hdr[10] = 8'($urandom());
      hdr[11] = 8'($urandom());
      for (int i = 0; i < keep; i++)
         send_byte(hdr[i]);
   endtask

   task automatic send_frame(input logic [19:0] blk);
      send_header(TAG_WVPK, {12'd0, blk} - 32'd8, 16'(field_value()), field_value(),
                  field_value(), field_value(), field_value() & 32'h7fff_ffff, 32);
      if (blk > wbsd_pkg::HDR_LEN)
         send_body(int'(blk - wbsd_pkg::HDR_LEN));
   endtask

   task automatic send_broken();
      logic [31:0] size_word;
      size_word = {12'd0, pick_block_size()} - 32'd8;
      case ($urandom_range(0, 4))
         0: send_header(TAG_WVPK, size_word, 16'(field_value()), field_value(),
                        field_value(), field_value(), field_value() | 32'h8000_0000, 32);
         1: send_header(TAG_WVPK, size_word ^ 32'd1, 16'(field_value()), field_value(),
                        field_value(), field_value(), 32'd0, 32);
         2: send_header(TAG_WVPK, {12'($urandom_range(1, 4094)),
                                   20'($urandom_range(0, 20'h7fff8) * 2)},
                        16'(field_value()), field_value(), field_value(),
                        field_value(), 32'd0, 32);
         3: send_header(TAG_WVPK ^ (32'd1 << $urandom_range(0, 31)), size_word,
                        16'(field_value()), field_value(), field_value(),
                        field_value(), 32'd0, 32);
         // A header cut short, so the next request's bytes complete the window.
         default: send_header(TAG_WVPK, size_word, 16'(field_value()), field_value(),
                              field_value(), field_value(), field_value() & 32'h7fff_ffff,
                              $urandom_range(1, 31));
      endcase
   endtask

   task automatic random_phase(input int n);
      phase_bytes = 0;
      while (phase_bytes < n) begin
         case ($urandom_range(0, 9))
            0: send_body($urandom_range(1, 40));
            1: send_broken();
            default: send_frame(pick_block_size());
         endcase
      end
   endtask

   task automatic wait_drained();
      if (req_valid)
         req_valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (results_due != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // Leaves the block searching with an empty window and no bytes skipped.
   task automatic settle();
      wait_drained();
      while (!in_sync) begin
         send_frame(pick_block_size());
         wait_drained();
      end
   endtask

   task automatic write_limit(input logic [23:0] v);
      @(posedge clock);
      csr_valid      <= 1'b1;
      csr_sync_limit <= v;
      @(negedge clock);
      while (!csr_ready)
         @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver: a random pattern, one long hold-off, then stall segments.
   initial begin
      int style;
      int span;
      @(negedge reset);
      repeat (300) begin
         @(posedge clock);
         rsp_ready <= 1'($urandom_range(0, 1));
      end
      @(posedge clock);
      rsp_ready <= 1'b0;
      repeat (400) @(posedge clock);
      forever begin
         style = $urandom_range(0, 3);
         span  = $urandom_range(10, 60);
         repeat (span) begin
            @(posedge clock);
            case (style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Extreme header fields and body bytes at both ends of the range.
      send_header(TAG_WVPK, 32'd32, 16'hffff, '1, '0, '1, 32'h7fff_ffff, 32);
      send_byte(8'h00);
      send_byte(8'hff);
      send_body(6);
      // Blocks of exactly header length, and sizes that wrap round to small values.
      send_header(TAG_WVPK, 32'd24, 16'h0000, '0, '1, '0, 32'd0, 32);
      send_header(TAG_WVPK, 32'hffff_fff8, 16'h1234, '1, '1, '1, 32'd0, 32);
      send_header(TAG_WVPK, 32'hffff_fffe, 16'h0407, '0, '0, '0, 32'd0, 32);
      // A few stray bytes ahead of a header are reported as skipped.
      send_body(3);
      send_frame(20'd34);
      // Rejected headers back to back: top flag bit, odd size, 1 MiB, largest size
      // with a bad flag and a damaged tag. The good block after them reports every
      // byte that they cost.
      send_header(TAG_WVPK, 32'd32, 16'h0410, '1, '0, '1, 32'h8000_0000, 32);
      send_header(TAG_WVPK, 32'd33, 16'h0410, '0, '0, '0, 32'd0, 32);
      send_header(TAG_WVPK, 32'h000f_fff8, 16'h0410, '0, '0, '0, 32'd0, 32);
      send_header(TAG_WVPK, 32'h000f_fff6, 16'h0410, '0, '0, '0, '1, 32);
      send_header(TAG_WVPK ^ 32'h0000_0100, 32'd32, 16'h0410, '0, '0, '0, 32'd0, 32);
      send_frame(20'd36);

      settle();
      write_limit(24'hff_ffff);
      random_phase(40);

      // With a limit of one, only well-formed blocks with at most one stray byte.
      settle();
      write_limit(24'd1);
      phase_bytes = 0;
      while (phase_bytes < 40) begin
         if ($urandom_range(0, 2) == 0)
            send_byte(8'($urandom()));
         send_frame(pick_block_size());
      end

      settle();
      write_limit(($urandom_range(0, 1) == 0) ? 24'd16777214
                                              : 24'($urandom_range(4096, 16777213)));
      random_phase(40);

      // A zero limit turns the first dropped byte into the no-sync error; the
      // block then swallows everything that follows.
      settle();
      write_limit(24'd0);
      send_body(32 + $urandom_range(10, 40));

      wait_drained();
      if (err_count == 0 && results_due == 0)
         $display("PASS wavpack_block_sync_deframer");
      else
         $display("FAIL wavpack_block_sync_deframer");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/wbsd_pkg.sv
rtl/wbsd_hdr_check.sv
rtl/wavpack_block_sync_deframer.sv
tb/wbsd_deframe_check.sv
tb/tb.sv
